// ===== hw/rtl/arp_pkg.sv =====
// Package for the pivot rotation core: widths, CORDIC constants, axis codes
// and the record that walks down the CORDIC cell chain.
// No dependencies.
`timescale 1ns / 1ps

package arp_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  // Fraction bits added below the coordinate LSB inside the CORDIC
  localparam int GUARD_BITS    = 12;
  // Angle held in fractions of a turn, 2^TURN_BITS per full turn
  localparam int TURN_BITS     = 32;
  // Gain compensation constant, Q0.GAIN_FRAC
  localparam int GAIN_FRAC     = 32;
  localparam logic [GAIN_FRAC-1:0] GAIN_Q32 = 32'd2608131496;

  // Difference point - pivot is exact in one more bit
  localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
  // Full gain product of a difference magnitude and the gain
  localparam int PROD_WIDTH    = DIFF_WIDTH + GAIN_FRAC;
  // Right shift that turns the product back into guard-bit scale
  localparam int SCALE_SHIFT   = GAIN_FRAC - GUARD_BITS;
  // Magnitude after gain scaling
  localparam int SCALE_WIDTH   = PROD_WIDTH - SCALE_SHIFT;
  // CORDIC datapath width: sign plus headroom for the CORDIC gain
  localparam int UV_WIDTH      = SCALE_WIDTH + 3;
  // Coordinate after dropping guard bits, and its sum with the pivot
  localparam int ROUND_WIDTH   = UV_WIDTH - GUARD_BITS;
  localparam int SUM_WIDTH     = ROUND_WIDTH + 1;

  localparam int STAGE_IDX_WIDTH = $clog2(CORDIC_STAGES);

  // Quarter turn, bound of the CORDIC convergence range
  localparam logic signed [TURN_BITS-1:0] QUARTER_TURN = TURN_BITS'(64'sd1 <<< (TURN_BITS - 2));

  // Rotation axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // atan(2^-i) in fractions of a turn, scaled by 2^TURN_BITS
  localparam logic [TURN_BITS-1:0] ATAN_TURN [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Data that rides alongside the rotation: what the output stage needs
  typedef struct packed {
    logic [1:0]                    action;
    logic signed [COORD_WIDTH-1:0] pt_x;
    logic signed [COORD_WIDTH-1:0] pt_y;
    logic signed [COORD_WIDTH-1:0] pt_z;
    logic signed [COORD_WIDTH-1:0] cu;
    logic signed [COORD_WIDTH-1:0] cv;
  } side_t;

  // One slot of the CORDIC chain
  typedef struct packed {
    logic                        valid;
    logic signed [UV_WIDTH-1:0]  u;
    logic signed [UV_WIDTH-1:0]  v;
    logic signed [TURN_BITS-1:0] z;
    side_t                       side;
  } cell_data_t;

endpackage

// ===== hw/rtl/arp_prep.sv =====
// Front end of the pivot rotation core: pair select, pivot subtract,
// quadrant fold and gain compensation, five register stages.
// Depends on arp_pkg.
`timescale 1ns / 1ps

module arp_prep import arp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [1:0]                    action,
  input  logic signed [COORD_WIDTH-1:0] pivot_x,
  input  logic signed [COORD_WIDTH-1:0] pivot_y,
  input  logic signed [COORD_WIDTH-1:0] pivot_z,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic [ANGLE_WIDTH-1:0]        angle,
  output cell_data_t                    out
);

  logic signed [COORD_WIDTH-1:0] pu, pv, cu, cv;
  logic [TURN_BITS-1:0]          z_raw;
  logic                          flip;

  // Stage 1 registers
  logic                          s1_valid;
  side_t                         s1_side;
  logic signed [DIFF_WIDTH-1:0]  s1_du, s1_dv;
  logic                          s1_flip;
  logic [TURN_BITS-1:0]          s1_z;

  // Stage 2 registers
  logic                          s2_valid;
  side_t                         s2_side;
  logic [DIFF_WIDTH-1:0]         s2_mag_u, s2_mag_v;
  logic                          s2_neg_u, s2_neg_v;
  logic [TURN_BITS-1:0]          s2_z;

  // Stage 3 registers
  logic                          s3_valid;
  side_t                         s3_side;
  logic [PROD_WIDTH-2:0]         s3_prod_u, s3_prod_v;
  logic                          s3_top_u, s3_top_v;
  logic                          s3_neg_u, s3_neg_v;
  logic [TURN_BITS-1:0]          s3_z;

  // Stage 4 registers
  logic                          s4_valid;
  side_t                         s4_side;
  logic [SCALE_WIDTH-1:0]        s4_r_u, s4_r_v;
  logic                          s4_neg_u, s4_neg_v;
  logic [TURN_BITS-1:0]          s4_z;

  logic [PROD_WIDTH-1:0]         sum_u, sum_v;
  logic [UV_WIDTH-1:0]           ext_u, ext_v;

  // Pick the pair that turns about the chosen axis
  always_comb begin
    unique case (action)
      AXIS_X: begin
        pu = point_y; pv = point_z; cu = pivot_y; cv = pivot_z;
      end
      AXIS_Y: begin
        pu = point_z; pv = point_x; cu = pivot_z; cv = pivot_x;
      end
      default: begin
        pu = point_x; pv = point_y; cu = pivot_x; cv = pivot_y;
      end
    endcase
  end

  // Negated angle in turn units, folded into the convergence range
  assign z_raw = TURN_BITS'(0) - {angle, {(TURN_BITS - ANGLE_WIDTH){1'b0}}};
  assign flip  = ($signed(z_raw) > QUARTER_TURN) || ($signed(z_raw) < -QUARTER_TURN);

  // Gain product plus top magnitude bit, rounded back to guard scale
  assign sum_u = {1'b0, s3_prod_u}
               + (s3_top_u ? {1'b0, GAIN_Q32, {(PROD_WIDTH - GAIN_FRAC - 1){1'b0}}}
                           : PROD_WIDTH'(0))
               + PROD_WIDTH'(64'd1 << (SCALE_SHIFT - 1));
  assign sum_v = {1'b0, s3_prod_v}
               + (s3_top_v ? {1'b0, GAIN_Q32, {(PROD_WIDTH - GAIN_FRAC - 1){1'b0}}}
                           : PROD_WIDTH'(0))
               + PROD_WIDTH'(64'd1 << (SCALE_SHIFT - 1));

  assign ext_u = {{(UV_WIDTH - SCALE_WIDTH){1'b0}}, s4_r_u};
  assign ext_v = {{(UV_WIDTH - SCALE_WIDTH){1'b0}}, s4_r_v};

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    // Stage 1: subtract pivot, fold angle
    s1_side.action <= action;
    s1_side.pt_x   <= point_x;
    s1_side.pt_y   <= point_y;
    s1_side.pt_z   <= point_z;
    s1_side.cu     <= cu;
    s1_side.cv     <= cv;
    s1_du   <= $signed({pu[COORD_WIDTH-1], pu}) - $signed({cu[COORD_WIDTH-1], cu});
    s1_dv   <= $signed({pv[COORD_WIDTH-1], pv}) - $signed({cv[COORD_WIDTH-1], cv});
    s1_flip <= flip;
    s1_z    <= {z_raw[TURN_BITS-1] ^ flip, z_raw[TURN_BITS-2:0]};

    // Stage 2: magnitude, sign merged with the quadrant fold
    s2_side  <= s1_side;
    s2_mag_u <= s1_du[DIFF_WIDTH-1] ? DIFF_WIDTH'(-s1_du) : DIFF_WIDTH'(s1_du);
    s2_mag_v <= s1_dv[DIFF_WIDTH-1] ? DIFF_WIDTH'(-s1_dv) : DIFF_WIDTH'(s1_dv);
    s2_neg_u <= s1_du[DIFF_WIDTH-1] ^ s1_flip;
    s2_neg_v <= s1_dv[DIFF_WIDTH-1] ^ s1_flip;
    s2_z     <= s1_z;

    // Stage 3: multiply the low word by the gain
    s3_side   <= s2_side;
    s3_prod_u <= (PROD_WIDTH-1)'(s2_mag_u[DIFF_WIDTH-2:0] * GAIN_Q32);
    s3_prod_v <= (PROD_WIDTH-1)'(s2_mag_v[DIFF_WIDTH-2:0] * GAIN_Q32);
    s3_top_u  <= s2_mag_u[DIFF_WIDTH-1];
    s3_top_v  <= s2_mag_v[DIFF_WIDTH-1];
    s3_neg_u  <= s2_neg_u;
    s3_neg_v  <= s2_neg_v;
    s3_z      <= s2_z;

    // Stage 4: add top partial product and round half up on the magnitude
    s4_side  <= s3_side;
    s4_r_u   <= sum_u[PROD_WIDTH-1:SCALE_SHIFT];
    s4_r_v   <= sum_v[PROD_WIDTH-1:SCALE_SHIFT];
    s4_neg_u <= s3_neg_u;
    s4_neg_v <= s3_neg_v;
    s4_z     <= s3_z;

    // Stage 5: restore sign; only the valid flag clears on reset
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= s4_valid;
    end
    out.side <= s4_side;
    out.u    <= s4_neg_u ? $signed(UV_WIDTH'(0) - ext_u) : $signed(ext_u);
    out.v    <= s4_neg_v ? $signed(UV_WIDTH'(0) - ext_v) : $signed(ext_v);
    out.z    <= $signed(s4_z);
  end

endmodule

// ===== hw/rtl/arp_cordic_cell.sv =====
// One CORDIC rotation cell: a shift-add micro-rotation and an angle update,
// registered. Depends on arp_pkg.
`timescale 1ns / 1ps

module arp_cordic_cell import arp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [STAGE_IDX_WIDTH-1:0] shift,
  input  logic [TURN_BITS-1:0]       atan_step,
  input  cell_data_t                 in,
  output cell_data_t                 out
);

  logic signed [UV_WIDTH-1:0]  u, v, du, dv;
  logic signed [TURN_BITS-1:0] z, step;

  assign u    = in.u;
  assign v    = in.v;
  assign z    = in.z;
  assign step = $signed(atan_step);
  assign du   = v >>> shift;
  assign dv   = u >>> shift;

  // Rotate toward zero residual angle; only the valid flag clears on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= in.valid;
    end
    out.side <= in.side;
    if (!z[TURN_BITS-1]) begin
      out.u <= u - du;
      out.v <= v + dv;
      out.z <= z - step;
    end else begin
      out.u <= u + du;
      out.v <= v - dv;
      out.z <= z + step;
    end
  end

endmodule

// ===== hw/rtl/arp_post.sv =====
// Back end of the pivot rotation core: drop guard bits with rounding,
// add the pivot back, saturate and place the coordinates. Two stages.
// Depends on arp_pkg.
`timescale 1ns / 1ps

module arp_post import arp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cell_data_t                    in,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] new_x,
  output logic signed [COORD_WIDTH-1:0] new_y,
  output logic signed [COORD_WIDTH-1:0] new_z
);

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  logic                          ra_valid;
  side_t                         ra_side;
  logic signed [ROUND_WIDTH-1:0] ra_u, ra_v;

  logic signed [UV_WIDTH-1:0]    rnd_u, rnd_v;
  logic signed [SUM_WIDTH-1:0]   sum_u, sum_v;
  logic signed [COORD_WIDTH-1:0] sat_u, sat_v;
  logic signed [COORD_WIDTH-1:0] x_next, y_next, z_next;

  // Round half up, then floor shift out the guard bits
  assign rnd_u = (in.u + UV_WIDTH'(64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
  assign rnd_v = (in.v + UV_WIDTH'(64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;

  // Add the pivot back
  assign sum_u = $signed({ra_u[ROUND_WIDTH-1], ra_u})
               + SUM_WIDTH'(ra_side.cu);
  assign sum_v = $signed({ra_v[ROUND_WIDTH-1], ra_v})
               + SUM_WIDTH'(ra_side.cv);

  // Saturate to the coordinate range
  always_comb begin
    if ((&sum_u[SUM_WIDTH-1:COORD_WIDTH-1]) || !(|sum_u[SUM_WIDTH-1:COORD_WIDTH-1])) begin
      sat_u = sum_u[COORD_WIDTH-1:0];
    end else if (sum_u[SUM_WIDTH-1]) begin
      sat_u = COORD_MIN;
    end else begin
      sat_u = COORD_MAX;
    end
    if ((&sum_v[SUM_WIDTH-1:COORD_WIDTH-1]) || !(|sum_v[SUM_WIDTH-1:COORD_WIDTH-1])) begin
      sat_v = sum_v[COORD_WIDTH-1:0];
    end else if (sum_v[SUM_WIDTH-1]) begin
      sat_v = COORD_MIN;
    end else begin
      sat_v = COORD_MAX;
    end
  end

  // Place the rotated pair; the axis coordinate passes through
  always_comb begin
    x_next = ra_side.pt_x;
    y_next = ra_side.pt_y;
    z_next = ra_side.pt_z;
    unique case (ra_side.action)
      AXIS_X: begin
        y_next = sat_u; z_next = sat_v;
      end
      AXIS_Y: begin
        z_next = sat_u; x_next = sat_v;
      end
      AXIS_Z: begin
        x_next = sat_u; y_next = sat_v;
      end
      default: begin
        x_next = ra_side.pt_x;
      end
    endcase
  end

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ra_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      ra_valid <= in.valid;
      done     <= ra_valid;
    end
  end

  // Hold rounded pair, then the result
  always_ff @(posedge clk) begin
    ra_side <= in.side;
    ra_u    <= rnd_u[ROUND_WIDTH-1:0];
    ra_v    <= rnd_v[ROUND_WIDTH-1:0];
    new_x   <= x_next;
    new_y   <= y_next;
    new_z   <= z_next;
  end

endmodule

// ===== hw/rtl/axis_rotate_about_pivot_core.sv =====
// Channel   Ports                                          Handshake
// input     action pivot_x/y/z point_x/y/z angle           start && !busy
// result    new_x new_y new_z                              done, one cycle
//
// Rotates a point about a line through a pivot parallel to the X, Y or Z
// axis with a gain-compensated CORDIC chain of CORDIC_STAGES cells.
// Takes one item every cycle; busy stays low. The path runs through 5
// front-end stages, the cell chain of CORDIC_STAGES cells and 2 output stages.
// rst is synchronous and clears only the valid flags of the pipeline.
// The receiver cannot stall: each result shows for one cycle under done.
// Depends on arp_pkg, arp_prep, arp_cordic_cell, arp_post.
`timescale 1ns / 1ps

module axis_rotate_about_pivot_core import arp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic signed [COORD_WIDTH-1:0] pivot_x,
  input  logic signed [COORD_WIDTH-1:0] pivot_y,
  input  logic signed [COORD_WIDTH-1:0] pivot_z,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic [ANGLE_WIDTH-1:0]        angle,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] new_x,
  output logic signed [COORD_WIDTH-1:0] new_y,
  output logic signed [COORD_WIDTH-1:0] new_z
);

  cell_data_t chain [CORDIC_STAGES+1];

  // Fully pipelined: every cycle takes an item
  assign busy = 1'b0;

  arp_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .action   (action),
    .pivot_x  (pivot_x),
    .pivot_y  (pivot_y),
    .pivot_z  (pivot_z),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .angle    (angle),
    .out      (chain[0])
  );

  // Chain of micro-rotation cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    arp_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (STAGE_IDX_WIDTH'(i)),
      .atan_step (ATAN_TURN[i]),
      .in        (chain[i]),
      .out       (chain[i+1])
    );
  end

  arp_post u_post (
    .clk   (clk),
    .rst   (rst),
    .in    (chain[CORDIC_STAGES]),
    .done  (done),
    .new_x (new_x),
    .new_y (new_y),
    .new_z (new_z)
  );

endmodule
